FILE: src/lshs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lshs_pkg
// Shared types and constants of the limit switch homing sequencer: homing
// stage codes, motion command codes, speed modes, register indexes and the
// result record handed to the motion generator.
// ----------------------------------------------------------------------------
package lshs_pkg;

  // Field widths
  localparam int TimeW     = 32;
  localparam int DebounceW = 16;
  localparam int StepsW    = 24;
  localparam int HomePosW  = 31;
  localparam int PosW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  // Result slots per pass and the index that walks them
  localparam int NumSlots = 3;
  localparam int SlotIdxW = 2;

  // Register reset values
  localparam logic [DebounceW-1:0] DebounceReset = 16'd50;
  localparam logic [TimeW-1:0]     TimeoutReset  = 32'd30000;
  localparam logic [TimeW-1:0]     HoldReset     = 32'd10000;
  localparam logic [StepsW-1:0]    CoarseReset   = 24'd100000;
  localparam logic [StepsW-1:0]    BackoffReset  = 24'd1000;
  localparam logic [StepsW-1:0]    FineReset     = 24'd5000;
  localparam logic [HomePosW-1:0]  HomePosReset  = 31'd0;

  typedef enum logic [2:0] {
    STAGE_IDLE    = 3'd0,
    STAGE_COARSE  = 3'd1,
    STAGE_WAIT    = 3'd2,
    STAGE_BACKOFF = 3'd3,
    STAGE_FINE    = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    CMD_STOP  = 3'd0,
    CMD_RUN   = 3'd1,
    CMD_REL   = 3'd2,
    CMD_ABS   = 3'd3,
    CMD_HOME  = 3'd4,
    CMD_ABORT = 3'd5,
    CMD_START = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    SPEED_NORMAL = 2'd0,
    SPEED_FAST   = 2'd1,
    SPEED_SLOW   = 2'd2
  } speed_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_TIMEOUT  = 3'd1,
    CFG_HOLD     = 3'd2,
    CFG_COARSE   = 3'd3,
    CFG_BACKOFF  = 3'd4,
    CFG_FINE     = 3'd5,
    CFG_HOME_POS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PosW-1:0]   pos;
    speed_t            spd;
  } result_t;

endpackage

FILE: src/limit_switch_homing_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_switch_homing_sequencer
// Debounces home switch events and sequences a homing run (coarse approach,
// wait for stop, fast backoff, slow fine approach) as motion commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one control pass per request:
//   now_ms, switch_fell, at_target. Output channel (out_valid / out_stall)
//   carries the commands a pass causes, zero to two, in order; last marks
//   the final command of a pass. Registers are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while the block is
//   idle, which the block does not enforce; indexes past the list are ignored.
//   Flow: a request is held in the input register and is evaluated into
//   the result buffer once that buffer is empty or its last command is
//   being taken; the pass's first command is then valid in the result
//   buffer. The result buffer drains one command per cycle while the
//   receiver does not stall; the next pass is evaluated in the cycle its
//   predecessor's last command is taken.
//   When the receiver stalls, the current command holds; the input register
//   still takes one request and then raises in_stall.
//   Reset (rst, synchronous) restores register defaults, returns to idle,
//   clears the lockout and event times, and empties both buffers.
// ----------------------------------------------------------------------------
module limit_switch_homing_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [lshs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [lshs_pkg::CfgDataW-1:0]    cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lshs_pkg::TimeW-1:0]       now_ms,
  input  logic                             switch_fell,
  input  logic                             at_target,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       command,
  output logic signed [lshs_pkg::PosW-1:0] position_value,
  output logic [1:0]                       speed_mode,
  output logic                             last
);

  // Configuration registers
  logic [lshs_pkg::DebounceW-1:0] debounce_ms;
  logic [lshs_pkg::TimeW-1:0]     timeout_ms;
  logic [lshs_pkg::TimeW-1:0]     hold_ms;
  logic [lshs_pkg::StepsW-1:0]    coarse_steps;
  logic [lshs_pkg::StepsW-1:0]    backoff_steps;
  logic [lshs_pkg::StepsW-1:0]    fine_steps;
  logic [lshs_pkg::HomePosW-1:0]  home_position;

  // Sequencer state
  lshs_pkg::stage_t           stage, stage_mid, stage_next;
  logic                       going_home, going_home_next;
  logic [lshs_pkg::TimeW-1:0] last_event_time, homing_start_time;
  logic [lshs_pkg::TimeW-1:0] trigger_time, stop_time;

  // Input register
  logic                       inq_valid;
  logic [lshs_pkg::TimeW-1:0] inq_now;
  logic                       inq_sw;
  logic                       inq_at;

  // Result buffer
  lshs_pkg::result_t             batch [lshs_pkg::NumSlots];
  logic [lshs_pkg::SlotIdxW-1:0] batch_cnt, batch_idx;
  logic                          batch_valid;

  // Pass evaluation
  lshs_pkg::result_t             slot [lshs_pkg::NumSlots];
  logic [lshs_pkg::SlotIdxW-1:0] slot_cnt;
  logic                          in_accept, batch_take, batch_done, load;
  logic                          in_homing, ev_ok, ev_homing, start_homing;
  logic                          coarse_late, fine_late, lock_clear;
  lshs_pkg::result_t             out_rec;

  // Handshake
  assign in_accept  = in_valid && !in_stall;
  assign batch_take = batch_valid && !out_stall;
  assign batch_done = batch_take && (batch_idx == batch_cnt - 2'd1);
  assign load       = inq_valid && (!batch_valid || batch_done);
  assign in_stall   = inq_valid && !load;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= lshs_pkg::DebounceReset;
      timeout_ms    <= lshs_pkg::TimeoutReset;
      hold_ms       <= lshs_pkg::HoldReset;
      coarse_steps  <= lshs_pkg::CoarseReset;
      backoff_steps <= lshs_pkg::BackoffReset;
      fine_steps    <= lshs_pkg::FineReset;
      home_position <= lshs_pkg::HomePosReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lshs_pkg::CFG_DEBOUNCE: debounce_ms   <= cfg_data[lshs_pkg::DebounceW-1:0];
        lshs_pkg::CFG_TIMEOUT:  timeout_ms    <= cfg_data;
        lshs_pkg::CFG_HOLD:     hold_ms       <= cfg_data;
        lshs_pkg::CFG_COARSE:   coarse_steps  <= cfg_data[lshs_pkg::StepsW-1:0];
        lshs_pkg::CFG_BACKOFF:  backoff_steps <= cfg_data[lshs_pkg::StepsW-1:0];
        lshs_pkg::CFG_FINE:     fine_steps    <= cfg_data[lshs_pkg::StepsW-1:0];
        lshs_pkg::CFG_HOME_POS: home_position <= cfg_data[lshs_pkg::HomePosW-1:0];
        default: ;
      endcase
    end
  end

  // Capture a request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_accept) begin
      inq_valid <= 1'b1;
    end else if (load) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      inq_now <= now_ms;
      inq_sw  <= switch_fell;
      inq_at  <= at_target;
    end
  end

  // Decode the switch event and the timers
  assign in_homing    = (stage == lshs_pkg::STAGE_COARSE) || (stage == lshs_pkg::STAGE_WAIT) ||
                        (stage == lshs_pkg::STAGE_BACKOFF) || (stage == lshs_pkg::STAGE_FINE);
  assign ev_ok        = inq_sw &&
                        ((inq_now - last_event_time) >= {16'd0, debounce_ms});
  assign ev_homing    = ev_ok && in_homing;
  assign start_homing = ev_ok && !in_homing && !going_home;
  assign coarse_late  = (inq_now - homing_start_time) > timeout_ms;
  assign fine_late    = (inq_now - trigger_time) > timeout_ms;
  assign lock_clear   = (inq_now - stop_time) >= hold_ms;

  // Stage after the switch event
  always_comb begin
    stage_mid = stage;
    if (ev_homing) begin
      unique case (stage)
        lshs_pkg::STAGE_COARSE: stage_mid = lshs_pkg::STAGE_WAIT;
        lshs_pkg::STAGE_FINE:   stage_mid = lshs_pkg::STAGE_IDLE;
        default:                stage_mid = stage;
      endcase
    end
  end

  // Next stage and lockout
  always_comb begin
    stage_next = stage_mid;
    unique case (stage_mid)
      lshs_pkg::STAGE_COARSE:
        if (coarse_late) stage_next = lshs_pkg::STAGE_IDLE;
      lshs_pkg::STAGE_WAIT:
        if (inq_at) stage_next = lshs_pkg::STAGE_BACKOFF;
      lshs_pkg::STAGE_BACKOFF:
        if (inq_at) stage_next = lshs_pkg::STAGE_FINE;
      lshs_pkg::STAGE_FINE:
        if (fine_late) stage_next = lshs_pkg::STAGE_IDLE;
      default: ;
    endcase
    if (start_homing) stage_next = lshs_pkg::STAGE_COARSE;

    going_home_next = going_home;
    if (going_home && lock_clear) going_home_next = 1'b0;
    if (start_homing) going_home_next = 1'b1;
  end

  // Build the commands of the pass in order
  always_comb begin
    for (int i = 0; i < lshs_pkg::NumSlots; i++) begin
      slot[i] = '{cmd: lshs_pkg::CMD_STOP, pos: '0, spd: lshs_pkg::SPEED_NORMAL};
    end
    slot_cnt = '0;

    // switch event: stop, and set home when it ends the fine approach
    if (ev_homing || start_homing) begin
      slot[slot_cnt] = '{cmd: lshs_pkg::CMD_STOP, pos: '0, spd: lshs_pkg::SPEED_NORMAL};
      slot_cnt = slot_cnt + 2'd1;
    end
    if (ev_homing && (stage == lshs_pkg::STAGE_FINE)) begin
      slot[slot_cnt] = '{cmd: lshs_pkg::CMD_HOME, pos: {1'b0, home_position},
                         spd: lshs_pkg::SPEED_NORMAL};
      slot_cnt = slot_cnt + 2'd1;
    end

    // stage action
    unique case (stage_mid)
      lshs_pkg::STAGE_COARSE: begin
        if (coarse_late) begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_ABORT, pos: '0, spd: lshs_pkg::SPEED_NORMAL};
        end else begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_RUN, pos: '0, spd: lshs_pkg::SPEED_FAST};
        end
        slot_cnt = slot_cnt + 2'd1;
      end
      lshs_pkg::STAGE_WAIT: begin
        if (inq_at) begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_REL, pos: {8'd0, backoff_steps},
                             spd: lshs_pkg::SPEED_FAST};
        end else begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_RUN, pos: '0, spd: lshs_pkg::SPEED_FAST};
        end
        slot_cnt = slot_cnt + 2'd1;
      end
      lshs_pkg::STAGE_BACKOFF: begin
        if (inq_at) begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_ABS, pos: 32'd0 - {8'd0, fine_steps},
                             spd: lshs_pkg::SPEED_SLOW};
        end else begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_RUN, pos: '0, spd: lshs_pkg::SPEED_FAST};
        end
        slot_cnt = slot_cnt + 2'd1;
      end
      lshs_pkg::STAGE_FINE: begin
        if (fine_late) begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_ABORT, pos: '0, spd: lshs_pkg::SPEED_NORMAL};
        end else begin
          slot[slot_cnt] = '{cmd: lshs_pkg::CMD_RUN, pos: '0, spd: lshs_pkg::SPEED_SLOW};
        end
        slot_cnt = slot_cnt + 2'd1;
      end
      default: ;
    endcase

    // start of homing
    if (start_homing) begin
      slot[slot_cnt] = '{cmd: lshs_pkg::CMD_START, pos: 32'd0 - {8'd0, coarse_steps},
                         spd: lshs_pkg::SPEED_FAST};
      slot_cnt = slot_cnt + 2'd1;
    end
  end

  // Advance the sequencer state when a pass is evaluated
  always_ff @(posedge clk) begin
    if (rst) begin
      stage             <= lshs_pkg::STAGE_IDLE;
      going_home        <= 1'b0;
      last_event_time   <= '0;
      homing_start_time <= '0;
      trigger_time      <= '0;
      stop_time         <= '0;
    end else if (load) begin
      stage      <= stage_next;
      going_home <= going_home_next;
      if (ev_ok) last_event_time <= inq_now;
      if (ev_homing || start_homing) trigger_time <= inq_now;
      if (start_homing) begin
        homing_start_time <= inq_now;
        stop_time         <= inq_now;
      end
    end
  end

  // Result buffer control: load a pass, step through its commands, drop when done
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_valid <= 1'b0;
      batch_cnt   <= '0;
      batch_idx   <= '0;
    end else if (load) begin
      batch_valid <= (slot_cnt != '0);
      batch_cnt   <= slot_cnt;
      batch_idx   <= '0;
    end else if (batch_done) begin
      batch_valid <= 1'b0;
    end else if (batch_take) begin
      batch_idx <= batch_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < lshs_pkg::NumSlots; i++) begin
        batch[i] <= slot[i];
      end
    end
  end

  // Drive the output channel
  assign out_rec        = batch[batch_idx];
  assign out_valid      = batch_valid;
  assign command        = out_rec.cmd;
  assign position_value = out_rec.pos;
  assign speed_mode     = out_rec.spd;
  assign last           = (batch_idx == batch_cnt - 2'd1);

  // Checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    batch_valid |-> (batch_cnt != '0) && (batch_idx < batch_cnt))
    else $error("result index outside the loaded pass");

  a_start_enters_coarse: assert property (@(posedge clk) disable iff (rst)
    load && start_homing |=> (stage == lshs_pkg::STAGE_COARSE) && going_home)
    else $error("homing start did not enter coarse approach with lockout set");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    batch_done && !load |=> !out_valid)
    else $error("result buffer still valid after its last command");

  a_home_ends_run: assert property (@(posedge clk) disable iff (rst)
    load && ev_homing && (stage == lshs_pkg::STAGE_FINE) |=> (stage == lshs_pkg::STAGE_IDLE))
    else $error("set home did not return the sequencer to idle");

endmodule

FILE: sim/limit_switch_homing_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_switch_homing_sequencer_tb
// Self-checking bench for the homing sequencer. A scoreboard class carries its
// own copy of the sequencer state and registers. It predicts the commands that
// each accepted control pass causes and checks every command that comes out
// against them, in order. Stimulus is a directed walk through the homing
// stages, then random passes steered by the predicted stage, over several
// register settings. The sender runs in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module limit_switch_homing_sequencer_tb;

  localparam int ClkHalfHi  = 6;
  localparam int ClkHalfLo  = 6;
  localparam int CycleLimit = 400000;
  localparam int SettleCyc  = 6;

  // One expected command
  typedef struct {
    lshs_pkg::cmd_t   cmd;
    logic [31:0]      pos;
    lshs_pkg::speed_t spd;
    logic             last;
  } cmd_rec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: sequencer state copy, expected command queue, checker
  // --------------------------------------------------------------------------
  class homing_scoreboard;
    logic [15:0] debounce;
    logic [31:0] timeout;
    logic [31:0] hold;
    logic [23:0] coarse;
    logic [23:0] backoff;
    logic [23:0] fine;
    logic [30:0] home_pos;

    lshs_pkg::stage_t stage;
    logic [31:0] last_evt;
    logic [31:0] run_start;
    logic [31:0] trig_t;
    logic [31:0] stop_t;
    bit          lockout;

    cmd_rec_t    want_cmds[$];
    int          errors;

    function new();
      debounce  = lshs_pkg::DebounceReset;
      timeout   = lshs_pkg::TimeoutReset;
      hold      = lshs_pkg::HoldReset;
      coarse    = lshs_pkg::CoarseReset;
      backoff   = lshs_pkg::BackoffReset;
      fine      = lshs_pkg::FineReset;
      home_pos  = lshs_pkg::HomePosReset;
      stage     = lshs_pkg::STAGE_IDLE;
      last_evt  = '0;
      run_start = '0;
      trig_t    = '0;
      stop_t    = '0;
      lockout   = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(lshs_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        lshs_pkg::CFG_DEBOUNCE: debounce = v[15:0];
        lshs_pkg::CFG_TIMEOUT:  timeout  = v;
        lshs_pkg::CFG_HOLD:     hold     = v;
        lshs_pkg::CFG_COARSE:   coarse   = v[23:0];
        lshs_pkg::CFG_BACKOFF:  backoff  = v[23:0];
        lshs_pkg::CFG_FINE:     fine     = v[23:0];
        lshs_pkg::CFG_HOME_POS: home_pos = v[30:0];
        default: ;
      endcase
    endfunction

    function void push_cmd(lshs_pkg::cmd_t c, logic [31:0] p, lshs_pkg::speed_t s);
      cmd_rec_t r;
      r.cmd  = c;
      r.pos  = p;
      r.spd  = s;
      r.last = 1'b0;
      want_cmds.push_back(r);
    endfunction

    // Advance the sequencer by one accepted pass and queue its commands
    function void note_request(logic [31:0] t, logic sw, logic at);
      int          n0;
      bit          start_run;
      logic [31:0] gap;
      n0 = want_cmds.size();
      start_run = 1'b0;

      // switch event, dropped when it bounces
      gap = t - last_evt;
      if (sw && gap >= {16'd0, debounce}) begin
        last_evt = t;
        if (stage != lshs_pkg::STAGE_IDLE) begin
          push_cmd(lshs_pkg::CMD_STOP, '0, lshs_pkg::SPEED_NORMAL);
          trig_t = t;
          if (stage == lshs_pkg::STAGE_COARSE) begin
            stage = lshs_pkg::STAGE_WAIT;
          end else if (stage == lshs_pkg::STAGE_FINE) begin
            push_cmd(lshs_pkg::CMD_HOME, {1'b0, home_pos}, lshs_pkg::SPEED_NORMAL);
            stage = lshs_pkg::STAGE_IDLE;
          end
        end else if (!lockout) begin
          push_cmd(lshs_pkg::CMD_STOP, '0, lshs_pkg::SPEED_NORMAL);
          stop_t = t;
          start_run = 1'b1;
        end
      end

      // homing stage
      case (stage)
        lshs_pkg::STAGE_COARSE: begin
          gap = t - run_start;
          if (gap > timeout) begin
            push_cmd(lshs_pkg::CMD_ABORT, '0, lshs_pkg::SPEED_NORMAL);
            stage = lshs_pkg::STAGE_IDLE;
          end else begin
            push_cmd(lshs_pkg::CMD_RUN, '0, lshs_pkg::SPEED_FAST);
          end
        end
        lshs_pkg::STAGE_WAIT: begin
          if (!at) begin
            push_cmd(lshs_pkg::CMD_RUN, '0, lshs_pkg::SPEED_FAST);
          end else begin
            push_cmd(lshs_pkg::CMD_REL, {8'd0, backoff}, lshs_pkg::SPEED_FAST);
            stage = lshs_pkg::STAGE_BACKOFF;
          end
        end
        lshs_pkg::STAGE_BACKOFF: begin
          if (!at) begin
            push_cmd(lshs_pkg::CMD_RUN, '0, lshs_pkg::SPEED_FAST);
          end else begin
            push_cmd(lshs_pkg::CMD_ABS, 32'd0 - {8'd0, fine}, lshs_pkg::SPEED_SLOW);
            stage = lshs_pkg::STAGE_FINE;
          end
        end
        lshs_pkg::STAGE_FINE: begin
          gap = t - trig_t;
          if (gap > timeout) begin
            push_cmd(lshs_pkg::CMD_ABORT, '0, lshs_pkg::SPEED_NORMAL);
            stage = lshs_pkg::STAGE_IDLE;
          end else begin
            push_cmd(lshs_pkg::CMD_RUN, '0, lshs_pkg::SPEED_SLOW);
          end
        end
        default: ;
      endcase

      // lockout clear
      gap = t - stop_t;
      if (lockout && gap >= hold) lockout = 1'b0;

      // start of a homing run
      if (start_run) begin
        lockout = 1'b1;
        push_cmd(lshs_pkg::CMD_START, 32'd0 - {8'd0, coarse}, lshs_pkg::SPEED_FAST);
        stage = lshs_pkg::STAGE_COARSE;
        run_start = t;
        trig_t = t;
      end

      if (want_cmds.size() > n0) want_cmds[want_cmds.size() - 1].last = 1'b1;
    endfunction

    // Compare one delivered command with the oldest expectation
    function void check_command(logic [2:0] c, logic [31:0] p, logic [1:0] s, logic l);
      cmd_rec_t e;
      if (want_cmds.size() == 0) begin
        $error("command %0d delivered with none pending", c);
        errors++;
        return;
      end
      e = want_cmds.pop_front();
      if (c !== e.cmd) begin
        $error("command: expected %0d, got %0d", e.cmd, c);
        errors++;
      end
      if (p !== e.pos) begin
        $error("position_value: expected %0d, got %0d", $signed(e.pos), $signed(p));
        errors++;
      end
      if (s !== e.spd) begin
        $error("speed_mode: expected %0d, got %0d", e.spd, s);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return want_cmds.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [lshs_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [lshs_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [lshs_pkg::TimeW-1:0]    now_ms = '0;
  logic                          switch_fell = 1'b0;
  logic                          at_target = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [2:0]                    command;
  logic signed [lshs_pkg::PosW-1:0] position_value;
  logic [1:0]                    speed_mode;
  logic                          last;

  limit_switch_homing_sequencer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .now_ms         (now_ms),
    .switch_fell    (switch_fell),
    .at_target      (at_target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command        (command),
    .position_value (position_value),
    .speed_mode     (speed_mode),
    .last           (last)
  );

  homing_scoreboard sb = new();

  logic [31:0] clock_ms = '0;
  int          burst_left = 0;
  int          cycles = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          stall_phase = 0;

  // Clock
  always begin
    #ClkHalfHi clk = 1'b1;
    #ClkHalfLo clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall pattern: switch between modes at random
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 60);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      2: out_stall <= (stall_phase % 3 == 0);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Check every delivered command
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_command(command, position_value, speed_mode, last);
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one pass, hold it until taken, then maybe open a gap
  task automatic send_pass(input logic [31:0] t, input logic sw, input logic at);
    int gap;
    in_valid    <= 1'b1;
    now_ms      <= t;
    switch_fell <= sw;
    at_target   <= at;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(t, sw, at);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and let every pending command drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(input lshs_pkg::cfg_idx_t idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic write_all(input logic [31:0] deb, input logic [31:0] tmo,
                           input logic [31:0] hld, input logic [31:0] crs,
                           input logic [31:0] bck, input logic [31:0] fin,
                           input logic [31:0] hom);
    drain();
    write_reg(lshs_pkg::CFG_DEBOUNCE, deb);
    write_reg(lshs_pkg::CFG_TIMEOUT, tmo);
    write_reg(lshs_pkg::CFG_HOLD, hld);
    write_reg(lshs_pkg::CFG_COARSE, crs);
    write_reg(lshs_pkg::CFG_BACKOFF, bck);
    write_reg(lshs_pkg::CFG_FINE, fin);
    write_reg(lshs_pkg::CFG_HOME_POS, hom);
    cfg_we <= 1'b0;
  endtask

  // Time step: small, near debounce, near timeout, near hold, or any value
  function automatic logic [31:0] pick_gap(input bit for_event);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sb.lockout && sb.stage == lshs_pkg::STAGE_IDLE && sel < 30)
      return sb.hold + $urandom_range(0, 2) - 1;
    if (for_event && sel < 75) return {16'd0, sb.debounce} + $urandom_range(0, 3);
    if (sel < 12) return '0;
    if (sel < 60) return $urandom_range(1, 20);
    if (sel < 75) return {16'd0, sb.debounce} - 1;
    if (sel < 90) return sb.timeout + $urandom_range(0, 2) - 1;
    if (sel < 96) return sb.hold + $urandom_range(0, 2) - 1;
    return $urandom;
  endfunction

  // Random passes steered by the predicted stage, with some noise
  task automatic run_random(input int count);
    int unsigned roll;
    logic        sw;
    logic        at;
    logic [31:0] gap;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      at = 1'($urandom_range(0, 1));
      if (roll < 10) begin
        sw = 1'($urandom_range(0, 1));
        gap = $urandom;
      end else begin
        case (sb.stage)
          lshs_pkg::STAGE_IDLE:   sw = (roll < 75);
          lshs_pkg::STAGE_COARSE: sw = (roll < 40);
          lshs_pkg::STAGE_FINE:   sw = (roll < 40);
          default:                sw = (roll < 18);
        endcase
        gap = pick_gap(sw);
      end
      clock_ms = clock_ms + gap;
      send_pass(clock_ms, sw, at);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk at reset settings
    send_pass(32'd10, 1'b1, 1'b0);          // bounced edge
    send_pass(32'd100, 1'b0, 1'b0);         // idle, nothing happens
    send_pass(32'd100, 1'b1, 1'b0);         // stop and start homing
    send_pass(32'd120, 1'b0, 1'b1);         // coarse keeps running
    send_pass(32'd130, 1'b1, 1'b0);         // bounce during coarse
    send_pass(32'd200, 1'b1, 1'b0);         // trigger, wait for stop
    send_pass(32'd210, 1'b0, 1'b1);         // backoff move
    send_pass(32'd260, 1'b1, 1'b0);         // event during backoff
    send_pass(32'd270, 1'b0, 1'b1);         // fine approach
    send_pass(32'd280, 1'b0, 1'b0);         // fine keeps running
    send_pass(32'd400, 1'b1, 1'b0);         // set home
    send_pass(32'd500, 1'b1, 1'b1);         // lockout active, ignored
    send_pass(32'd10500, 1'b1, 1'b0);       // lockout clears after the event
    send_pass(32'd10600, 1'b1, 1'b0);       // start homing again
    send_pass(32'd40600, 1'b0, 1'b0);       // exactly at coarse timeout
    send_pass(32'd40601, 1'b0, 1'b0);       // coarse timeout abort
    send_pass(32'd50601, 1'b1, 1'b0);       // start homing
    send_pass(32'd50700, 1'b1, 1'b1);       // trigger and backoff together
    send_pass(32'd50710, 1'b0, 1'b1);       // fine approach
    send_pass(32'd80710, 1'b0, 1'b0);       // fine timeout abort
    send_pass(32'hFFFF_FFF0, 1'b1, 1'b0);   // start near wrap
    send_pass(32'h0000_0010, 1'b0, 1'b0);   // time wraps
    send_pass(32'hFFFF_FFFF, 1'b1, 1'b1);   // backwards step, bounced
    clock_ms = 32'hFFFF_FFFF;

    run_random(20);

    // All at minimum
    write_all('0, '0, '0, '0, '0, '0, '0);
    run_random(25);

    // All at maximum
    write_all(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF,
              32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF);
    run_random(30);

    // Moderate settings, junk above the register widths
    repeat (3) begin
      write_all({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 200))},
                $urandom_range(300, 3000), $urandom_range(0, 600),
                $urandom, $urandom, $urandom, $urandom);
      run_random(25);
    end

    drain();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
